// ===== rtl/core/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// Space-saving top-k table package
// Shared payload types, the carry record that runs along the cell chain and
// the write bus from the controller back into the cells.
// ----------------------------------------------------------------------------
package sst_pkg;

  // Widest slot index for the largest supported table (65536 slots).
  localparam int unsigned IdxW = 16;
  // Widest occupancy count for the largest supported table.
  localparam int unsigned OccW = 17;
  localparam logic [31:0] CntMax = 32'hFFFF_FFFF;

  // Operation codes of an input beat.
  localparam logic OpUpdate = 1'b0;
  localparam logic OpRead   = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] flow_id;
    logic [31:0] element_id;
    logic [7:0]  slot_index;
  } in_t;

  typedef struct packed {
    logic [7:0]  slot;
    logic [31:0] key_flow_id;
    logic [31:0] key_element_id;
    logic [31:0] count;
    logic        hit;
    logic        evicted;
    logic [31:0] evicted_flow_id;
    logic [31:0] evicted_element_id;
    logic [31:0] evicted_count;
    logic        entry_valid;
  } out_t;

  // Search record handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic            valid;
    logic            found;
    logic [IdxW-1:0] fidx;
    logic [63:0]     fkey;
    logic [31:0]     fcnt;
    logic            have;
    logic [IdxW-1:0] midx;
    logic [63:0]     mkey;
    logic [31:0]     mcnt;
  } carry_t;

  // Write of one entry, broadcast to all cells.
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] idx;
    logic [63:0]     key;
    logic [31:0]     cnt;
  } wr_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == CntMax) ? v : v + 32'd1;
  endfunction

endpackage

// ===== rtl/core/sst_cell.sv =====
// ----------------------------------------------------------------------------
// Space-saving table cell
// Holds one entry, folds it into the passing search record and registers the
// record for the next cell.
// ----------------------------------------------------------------------------
module sst_cell #(
  parameter int Idx = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sst_pkg::carry_t          carry_i,
  input  logic                     op_i,
  input  logic [63:0]              key_i,
  input  logic [7:0]               sidx_i,
  input  logic [sst_pkg::OccW-1:0] occ_i,
  input  sst_pkg::wr_t             wr_i,
  output sst_pkg::carry_t          carry_o
);
  import sst_pkg::*;

  logic [63:0] key_q;
  logic [31:0] cnt_q;
  carry_t      carry_d, carry_q;
  logic        occupied, match;

  assign occupied = int'(occ_i) > Idx;
  assign match    = (op_i == OpRead) ? (int'(sidx_i) == Idx)
                                     : (occupied && (key_q == key_i));

  // Fold this entry into the record: first match wins, strict minimum keeps
  // the lowest slot on a tie.
  always_comb begin
    carry_d = carry_i;
    if (!carry_i.found && match) begin
      carry_d.found = 1'b1;
      carry_d.fidx  = IdxW'(Idx);
      carry_d.fkey  = key_q;
      carry_d.fcnt  = cnt_q;
    end
    if ((op_i == OpUpdate) && occupied && (!carry_i.have || (cnt_q < carry_i.mcnt))) begin
      carry_d.have = 1'b1;
      carry_d.midx = IdxW'(Idx);
      carry_d.mkey = key_q;
      carry_d.mcnt = cnt_q;
    end
  end

  // Hand the record on to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
    end
  end

  // Entry storage, written from the controller's broadcast bus.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (int'(wr_i.idx) == Idx)) begin
      key_q <= wr_i.key;
      cnt_q <= wr_i.cnt;
    end
  end

  assign carry_o = carry_q;

endmodule

// ===== rtl/core/space_saving_topk_table.sv =====
// ----------------------------------------------------------------------------
// Space-saving top-k table
// Frequent-item table over 64-bit keys built as a chain of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   An input beat (in_i) is taken at a clock edge with start_i high and busy_o
//   low. An update looks the key up, then increments, inserts or replaces the
//   minimum entry; a read reports one slot. Every beat yields one result beat.
//   The result is shown on res_o for exactly one cycle with res_valid_o high;
//   the receiver cannot stall it.
//   Flow: the record is registered in launch_q, then walks the cell chain one
//   cell per cycle, registered in every cell, and the result is registered in
//   res_q. busy_o falls as the strobe rises, so the next beat can be taken at
//   the edge that ends the strobe cycle; no beat is taken while one is in flight.
//   Configuration: cfg_we_i writes active_entries from cfg_wdata_i; the user
//   must write it only while idle, the block itself does not enforce this.
//   Reset empties the table and sets active_entries to 256; no clearing pass is needed.
// ----------------------------------------------------------------------------
module space_saving_topk_table #(
  parameter int CAPACITY = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  sst_pkg::in_t  in_i,
  output logic          busy_o,
  input  logic          cfg_we_i,
  input  logic [8:0]    cfg_wdata_i,
  output logic          res_valid_o,
  output sst_pkg::out_t res_o
);
  import sst_pkg::*;

  localparam int OccBits = $clog2(CAPACITY + 1);

  logic               busy_q, launch_q, res_valid_q;
  logic [8:0]         active_q;
  logic [OccBits-1:0] occ_q;
  in_t                in_q;
  out_t               res_d, res_q;
  wr_t                wr;
  carry_t             head;
  carry_t             chain [CAPACITY+1];
  logic [8:0]         act_eff;
  logic               accept, tail, room;

  assign accept = start_i && !busy_q;
  assign tail   = chain[CAPACITY].valid;

  // Control: busy from acceptance until the record leaves the last cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      launch_q    <= 1'b0;
      res_valid_q <= 1'b0;
      active_q    <= 9'd256;
      occ_q       <= '0;
    end else begin
      launch_q    <= accept;
      res_valid_q <= tail;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (tail) begin
        busy_q <= 1'b0;
      end
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (tail && (in_q.op == OpUpdate) && !chain[CAPACITY].found && room) begin
        occ_q <= occ_q + OccBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i;
    end
    if (tail) begin
      res_q <= res_d;
    end
  end

  // Record entering the first cell.
  always_comb begin
    head       = '0;
    head.valid = launch_q;
    head.mcnt  = CntMax;
  end

  assign chain[0] = head;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sst_cell #(.Idx(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .carry_i (chain[g]),
      .op_i    (in_q.op),
      .key_i   ({in_q.flow_id, in_q.element_id}),
      .sidx_i  (in_q.slot_index),
      .occ_i   (OccW'(occ_q)),
      .wr_i    (wr),
      .carry_o (chain[g+1])
    );
  end

  // Effective limit: zero acts as one, anything above the capacity as the capacity.
  assign act_eff = (active_q == 9'd0) ? 9'd1 : active_q;
  assign room    = (int'(occ_q) < int'(act_eff)) && (int'(occ_q) < CAPACITY);

  // Decision when the record leaves the chain: result beat and entry write.
  always_comb begin
    res_d   = '0;
    wr      = '0;
    wr.key  = {in_q.flow_id, in_q.element_id};
    if (in_q.op == OpRead) begin
      res_d.slot        = in_q.slot_index;
      res_d.entry_valid = chain[CAPACITY].found && (int'(in_q.slot_index) < int'(occ_q));
      if (res_d.entry_valid) begin
        res_d.key_flow_id    = chain[CAPACITY].fkey[63:32];
        res_d.key_element_id = chain[CAPACITY].fkey[31:0];
        res_d.count          = chain[CAPACITY].fcnt;
      end
    end else begin
      res_d.entry_valid    = 1'b1;
      res_d.key_flow_id    = in_q.flow_id;
      res_d.key_element_id = in_q.element_id;
      wr.en                = tail;
      if (chain[CAPACITY].found) begin
        res_d.hit = 1'b1;
        wr.idx    = chain[CAPACITY].fidx;
        wr.cnt    = sat_inc(chain[CAPACITY].fcnt);
      end else if (room) begin
        wr.idx = IdxW'(occ_q);
        wr.cnt = 32'd1;
      end else begin
        res_d.evicted            = 1'b1;
        res_d.evicted_flow_id    = chain[CAPACITY].mkey[63:32];
        res_d.evicted_element_id = chain[CAPACITY].mkey[31:0];
        res_d.evicted_count      = chain[CAPACITY].mcnt;
        wr.idx                   = chain[CAPACITY].midx;
        wr.cnt                   = sat_inc(chain[CAPACITY].mcnt);
      end
      res_d.slot  = wr.idx[7:0];
      res_d.count = wr.cnt;
    end
  end

  assign busy_o      = busy_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/core/sst_checker.sv =====
// ----------------------------------------------------------------------------
// Space-saving table port checker
// Watches the top level's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module sst_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          res_valid_o,
  input sst_pkg::out_t res_o
);
  import sst_pkg::*;

  // An accepted beat makes the block busy.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("busy not raised after accept");

  // A result beat is shown only once the block has gone idle.
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy_o) else $error("result while busy");

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.hit |-> !res_o.evicted) else $error("hit and evicted");

  // The eviction count stays zero without an eviction.
  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.evicted |-> res_o.evicted_count == 32'd0)
    else $error("eviction count without eviction");

  // A hit or an eviction always reports an occupied slot.
  a_evict_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.evicted || res_o.hit) |-> res_o.entry_valid)
    else $error("update reported empty slot");

endmodule

bind space_saving_topk_table sst_checker u_sst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
